### hw/rtl/oomvs_pkg.sv
// Shared types and constants for the OOM victim selector.
package oomvs_pkg;

    localparam int PID_W      = 32;
    localparam int PAGE_W     = 32;
    localparam int PRIV_W     = 8;
    localparam int FLAG_W     = 8;
    localparam int SCORE_W    = 39;
    localparam int DIVISOR_W  = PRIV_W + 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = $clog2(SCORE_W + 1);

    localparam logic [PID_W-1:0]   RESERVED_PID_RESET = PID_W'(99);
    localparam logic [PRIV_W-1:0]  PRIV_LIMIT_RESET   = PRIV_W'(9);
    localparam int                 SANDBOX_KERNEL_BIT = 1;
    localparam logic [SCORE_W-1:0] SCORE_SCALE        = SCORE_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESERVED_PID_LIMIT = 4'd0,
        CFG_PRIVILEGE_LIMIT    = 4'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [PID_W-1:0]  task_pid;
        logic              crit_flag;
        logic [FLAG_W-1:0] sandbox_bits;
        logic [PRIV_W-1:0] privilege;
        logic              kill_pending;
        logic [PAGE_W-1:0] page_count;
        logic              last_task;
    } task_t;

    typedef struct packed {
        logic               victim_found;
        logic [PID_W-1:0]   victim_pid;
        logic [SCORE_W-1:0] victim_score;
    } result_t;

endpackage

### hw/rtl/oomvs_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
interface oomvs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/oom_victim_selector.sv
// Top level of the OOM victim selector: eligibility check, scoring and best-victim tracking.
//
// Usage:
//   in_ch  carries one task descriptor per transaction; a scan is the run of
//          transactions up to and including the one with last_task set.
//   out_ch carries one result transaction per scan (found, pid, score).
//   cfg_we/cfg_index/cfg_wdata write reserved_pid_limit (index 0) and
//   privilege_limit (index 1); write only while no task is in flight.
// Operation:
//   in_ch.ready is high only while idle, so a task is accepted only while no
//   other task is being processed. An eligible task runs the x100 multiply,
//   a shared restoring divider (one quotient bit per cycle) and a
//   compare/update step. An ineligible task skips the multiply and the
//   divider and goes straight to the update step. A last task waits in the
//   update step until the output register is free; its result is loaded
//   there in the update cycle and shows on out_ch in the next cycle.
// Reset clears the scan state, restores both limits to 99 and 9, and drops
// out_ch.valid. A stalled receiver holds the result in the output register;
// the next scan proceeds until its own last task needs that register.
module oom_victim_selector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [oomvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [oomvs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    oomvs_stream_if.sink                    in_ch,
    oomvs_stream_if.source                  out_ch
);
    import oomvs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [PID_W-1:0]     pid_limit_reg;
    logic [PRIV_W-1:0]    priv_limit_reg;
    task_t                task_reg;
    logic                 elig_reg;
    logic [SCORE_W-1:0]   quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 have_best_reg, have_best_next;
    logic [PID_W-1:0]     best_pid_reg, best_pid_next;
    logic [SCORE_W-1:0]   best_score_reg, best_score_next;
    result_t              res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 accept;
    logic                 elig_in;
    logic [DIVISOR_W-1:0] divisor;
    logic [DIVISOR_W:0]   trial;
    logic                 trial_ge;
    logic                 better;
    logic                 out_free;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = res_reg;
    assign out_free     = !out_valid_reg || out_ch.ready;

    assign elig_in = (in_ch.data.task_pid != '0)
                  && (in_ch.data.task_pid > pid_limit_reg)
                  && !in_ch.data.crit_flag
                  && !in_ch.data.sandbox_bits[SANDBOX_KERNEL_BIT]
                  && (in_ch.data.privilege < priv_limit_reg)
                  && !in_ch.data.kill_pending;

    // Shared divider step: shift one dividend bit into the remainder.
    assign divisor  = {1'b0, task_reg.privilege} + DIVISOR_W'(1);
    assign trial    = {rem_reg, quo_reg[SCORE_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor});

    // quo_reg holds the finished quotient during the update cycle.
    assign better = elig_reg && (!have_best_reg || (quo_reg > best_score_reg)
                  || ((quo_reg == best_score_reg) && (task_reg.task_pid > best_pid_reg)));

    always_comb
    begin
        state_next      = state_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        have_best_next  = have_best_reg;
        best_pid_next   = best_pid_reg;
        best_score_next = best_score_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = elig_in ? ST_MUL : ST_UPD;
                end
            end
            ST_MUL:
            begin
                quo_next   = SCORE_W'(task_reg.page_count) * SCORE_SCALE;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? DIVISOR_W'(trial - {1'b0, divisor})
                                    : trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[SCORE_W-2:0], trial_ge};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(SCORE_W - 1))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (!task_reg.last_task)
                begin
                    if (better)
                    begin
                        have_best_next  = 1'b1;
                        best_pid_next   = task_reg.task_pid;
                        best_score_next = quo_reg;
                    end
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    if (better)
                    begin
                        res_next.victim_found = 1'b1;
                        res_next.victim_pid   = task_reg.task_pid;
                        res_next.victim_score = quo_reg;
                    end
                    else
                    begin
                        res_next.victim_found = have_best_reg;
                        res_next.victim_pid   = have_best_reg ? best_pid_reg : '0;
                        res_next.victim_score = have_best_reg ? best_score_reg : '0;
                    end
                    out_valid_next  = 1'b1;
                    have_best_next  = 1'b0;
                    best_pid_next   = '0;
                    best_score_next = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            have_best_reg  <= 1'b0;
            best_pid_reg   <= '0;
            best_score_reg <= '0;
            out_valid_reg  <= 1'b0;
            pid_limit_reg  <= RESERVED_PID_RESET;
            priv_limit_reg <= PRIV_LIMIT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            have_best_reg  <= have_best_next;
            best_pid_reg   <= best_pid_next;
            best_score_reg <= best_score_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RESERVED_PID_LIMIT: pid_limit_reg  <= cfg_wdata[PID_W-1:0];
                    CFG_PRIVILEGE_LIMIT:    priv_limit_reg <= cfg_wdata[PRIV_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            task_reg <= in_ch.data;
            elig_reg <= elig_in;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

endmodule

### test/tb.sv
// Self-checking testbench for oom_victim_selector: directed table, then random scans.
module tb;
    import oomvs_pkg::*;

    localparam int SETTLE_CYCLES = 50;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 63;

    typedef struct {
        task_t   item;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    oomvs_stream_if #(.payload_t(task_t))   task_ch ();
    oomvs_stream_if #(.payload_t(result_t)) result_ch ();

    oom_victim_selector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (task_ch),
        .out_ch    (result_ch)
    );

    // Local copy of the limits and of the running best candidate
    logic [PID_W-1:0]   pid_floor;
    logic [PRIV_W-1:0]  priv_ceiling;
    logic               lead_valid;
    logic [PID_W-1:0]   lead_pid;
    logic [SCORE_W-1:0] lead_score;

    result_t   victims_due[$];
    stim_row_t plan[$];

    int  errors;
    int  tasks_sent;
    int  scans_checked;
    int  victims_seen;
    int  cycles;
    bit  calm;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still due", $time, victims_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            result_ch.ready <= calm || ($urandom_range(99) >= 9);
    end

    function automatic task_t make_task(input logic [PID_W-1:0] pid, input logic crit,
                                        input logic [FLAG_W-1:0] flags,
                                        input logic [PRIV_W-1:0] priv, input logic pend,
                                        input logic [PAGE_W-1:0] pages, input logic last);
        task_t t;
        t.task_pid     = pid;
        t.crit_flag    = crit;
        t.sandbox_bits = flags;
        t.privilege    = priv;
        t.kill_pending = pend;
        t.page_count   = pages;
        t.last_task    = last;
        return t;
    endfunction

    // Fold one task into the running best; on the last task, hand back the verdict.
    function automatic bit rank_task(input task_t t, output result_t verdict);
        bit         eligible;
        bit [63:0]  score;
        eligible = t.task_pid != '0 && t.task_pid > pid_floor && !t.crit_flag &&
                   !t.sandbox_bits[SANDBOX_KERNEL_BIT] && t.privilege < priv_ceiling &&
                   !t.kill_pending;
        if (eligible)
        begin
            score = (64'(t.page_count) * 64'd100) / (64'(t.privilege) + 64'd1);
            if (!lead_valid || score[SCORE_W-1:0] > lead_score ||
                (score[SCORE_W-1:0] == lead_score && t.task_pid > lead_pid))
            begin
                lead_valid = 1'b1;
                lead_pid   = t.task_pid;
                lead_score = score[SCORE_W-1:0];
            end
        end
        verdict = '0;
        if (!t.last_task)
            return 1'b0;
        verdict.victim_found = lead_valid;
        verdict.victim_pid   = lead_valid ? lead_pid : '0;
        verdict.victim_score = lead_valid ? lead_score : '0;
        lead_valid = 1'b0;
        lead_pid   = '0;
        lead_score = '0;
        return 1'b1;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (victims_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction: expected none, actual pid %0d",
                         $time, result_ch.data.victim_pid);
            end
            else
            begin
                want = victims_due.pop_front();
                compare_field("victim_found", 64'(want.victim_found),
                              64'(result_ch.data.victim_found));
                compare_field("victim_pid", 64'(want.victim_pid),
                              64'(result_ch.data.victim_pid));
                compare_field("victim_score", 64'(want.victim_score),
                              64'(result_ch.data.victim_score));
                scans_checked++;
                if (want.victim_found)
                    victims_seen++;
            end
        end
    end

    // Offer one task until accepted, then record what it should produce.
    task automatic issue(input task_t t, input bit typed, input result_t typed_want);
        result_t verdict;
        while (!calm && $urandom_range(99) < 9)
        begin
            task_ch.valid <= 1'b0;
            @(posedge clk);
        end
        task_ch.valid <= 1'b1;
        task_ch.data  <= t;
        do
        begin
            @(posedge clk);
        end
        while (!task_ch.ready);
        tasks_sent++;
        if (rank_task(t, verdict))
            victims_due.push_back(typed ? typed_want : verdict);
    endtask

    // Block goes quiet: all results drained, and any ineligible/divider work finished.
    task automatic settle();
        task_ch.valid <= 1'b0;
        while (victims_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RESERVED_PID_LIMIT)
            pid_floor = value[PID_W-1:0];
        else
            priv_ceiling = value[PRIV_W-1:0];
    endtask

    function automatic task_t random_task();
        task_t t;
        case ($urandom_range(9))
            0: t.task_pid = '0;
            1: t.task_pid = pid_floor;
            2: t.task_pid = pid_floor + 1;
            3: t.task_pid = '1;
            4: t.task_pid = $urandom;
            default: t.task_pid = pid_floor + 1 + $urandom_range(200);
        endcase
        t.crit_flag    = ($urandom_range(9) == 0);
        t.sandbox_bits = $urandom;
        if ($urandom_range(3) != 0)
            t.sandbox_bits[SANDBOX_KERNEL_BIT] = 1'b0;
        if ($urandom_range(9) < 7 && priv_ceiling != '0)
            t.privilege = $urandom_range(int'(priv_ceiling) - 1);
        else
            t.privilege = $urandom_range(255);
        t.kill_pending = ($urandom_range(9) == 0);
        case ($urandom_range(7))
            0: t.page_count = '0;
            1: t.page_count = '1;
            2, 3: t.page_count = $urandom;
            default: t.page_count = $urandom_range(16);   // small counts make ties likely
        endcase
        t.last_task = ($urandom_range(4) == 0);
        return t;
    endfunction

    initial
    begin
        logic [PID_W-1:0]  next_floor;
        logic [PRIV_W-1:0] next_ceiling;
        result_t           none;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_RESERVED_PID_LIMIT;
        cfg_wdata       = '0;
        task_ch.valid   = 1'b0;
        task_ch.data    = '0;
        result_ch.ready = 1'b0;
        errors          = 0;
        tasks_sent      = 0;
        scans_checked   = 0;
        victims_seen    = 0;
        cycles          = 0;
        calm            = 1'b0;
        pid_floor       = RESERVED_PID_RESET;
        priv_ceiling    = PRIV_LIMIT_RESET;
        lead_valid      = 1'b0;
        lead_pid        = '0;
        lead_score      = '0;
        none            = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limits: pid must exceed 99, privilege must be below 9
        plan.push_back('{make_task(100, 0, 0, 0, 0, 0, 1), 1'b1,
                         result_t'{1'b1, 32'd100, 39'd0}});
        plan.push_back('{make_task(99, 0, 0, 0, 0, 5, 1), 1'b1, none});
        plan.push_back('{make_task(0, 0, 0, 0, 0, 5, 1), 1'b1, none});
        plan.push_back('{make_task('1, 0, 0, 0, 0, '1, 1), 1'b1,
                         result_t'{1'b1, 32'hFFFF_FFFF, 39'd429496729500}});
        plan.push_back('{make_task(200, 1, 0, 0, 0, 5, 1), 1'b1, none});
        plan.push_back('{make_task(200, 0, 8'h02, 0, 0, 5, 1), 1'b1, none});
        plan.push_back('{make_task(200, 0, 8'hFD, 8, 0, 7, 1), 1'b1,
                         result_t'{1'b1, 32'd200, 39'd77}});
        plan.push_back('{make_task(200, 0, 0, 9, 0, 5, 1), 1'b1, none});
        plan.push_back('{make_task(200, 0, 0, 0, 1, 5, 1), 1'b1, none});
        plan.push_back('{make_task(200, 0, 0, 255, 0, '1, 1), 1'b1, none});
        // equal scores: larger pid wins; skipped last task still closes the scan
        plan.push_back('{make_task(500, 0, 0, 0, 0, 10, 0), 1'b0, none});
        plan.push_back('{make_task(400, 0, 0, 0, 0, 10, 0), 1'b0, none});
        plan.push_back('{make_task(600, 0, 0, 1, 0, 20, 0), 1'b0, none});
        plan.push_back('{make_task(1, 0, 0, 0, 0, 99, 1), 1'b0, none});
        // eligible last task takes part before the verdict
        plan.push_back('{make_task(300, 0, 0, 0, 0, 1, 0), 1'b0, none});
        plan.push_back('{make_task(250, 0, 0, 8, 0, 1000, 1), 1'b0, none});
        plan.push_back('{make_task(700, 0, 0, 0, 0, 50, 0), 1'b0, none});
        plan.push_back('{make_task(800, 1, 8'hFF, 0, 1, 50, 0), 1'b0, none});
        plan.push_back('{make_task(900, 0, 0, 3, 0, 200, 1), 1'b0, none});
        plan.push_back('{make_task(1000, 0, 0, 0, 0, 300, 0), 1'b0, none});
        plan.push_back('{make_task(2000, 0, 0, 0, 0, 299, 1), 1'b0, none});

        foreach (plan[i])
            issue(plan[i].item, plan[i].typed, plan[i].want);

        // Phase boundaries may fall mid-scan, so limits also change within a scan
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0: begin next_floor = '0; next_ceiling = 8'd255; end
                1: begin next_floor = 32'd99; next_ceiling = 8'd9; end
                2: begin next_floor = '1; next_ceiling = 8'd255; end
                3: begin next_floor = '0; next_ceiling = '0; end
                default:
                begin
                    next_floor   = ($urandom_range(1) == 0) ? 32'($urandom)
                                                            : 32'($urandom_range(1000));
                    next_ceiling = $urandom_range(255, 1);
                end
            endcase
            write_reg(CFG_RESERVED_PID_LIMIT, next_floor);
            write_reg(CFG_PRIVILEGE_LIMIT, {8'($urandom), 16'($urandom), next_ceiling});
            calm = (phase == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue(random_task(), 1'b0, none);
        end
        calm = 1'b0;
        settle();

        $display("Covered %0d task transactions and %0d scan results, %0d with a victim.",
                 tasks_sent, scans_checked, victims_seen);
        $display("Limits exercised at reset values, both extremes and random pairs.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
